// ===== hdl/page_delta_record_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// page delta record encoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef PAGE_DELTA_RECORD_ENCODER_ASSERT_SVH
`define PAGE_DELTA_RECORD_ENCODER_ASSERT_SVH

// checked outside reset
`define PDRE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define PDRE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/pdre_pkg.sv =====
// ----------------------------------------------------------------------------
// pdre_pkg
// types, codes and default sizes of the page delta record encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdre_pkg;

   localparam int PAGE_BYTES_DEF  = 4096;
   localparam int GAP_LIMIT_DEF   = 16;
   localparam int NUM_SPANS_DEF   = 3;
   localparam int OFFSET_BITS_DEF = 32;

   localparam int OUT_OFF_BITS   = 40;
   localparam int WORD_BITS      = 64;
   localparam int SPAN_BITS      = 32;
   localparam int REC_BITS       = 32;
   localparam int PAY_BITS       = 33;
   localparam int CSR_INDEX_BITS = 3;
   localparam int FILL_BITS      = 3;
   localparam int WORD_BYTES     = 8;
   localparam int HDR_BYTES      = 16;

   localparam logic [1:0] KIND_ADDR = 2'd0;
   localparam logic [1:0] KIND_LEN  = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BASE_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPAN_COUNT   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPAN0_START  = 3'd2;

   typedef struct packed {
      logic [7:0] cur_byte;
      logic [7:0] prev_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [OUT_OFF_BITS-1:0] out_offset;
      logic [WORD_BITS-1:0]    out_word;
      logic [1:0]              word_kind;
      logic [REC_BITS-1:0]     record_total;
      logic [PAY_BITS-1:0]     payload_total;
      logic                    last_of_run;
   } rsp_type;

endpackage

// ===== hdl/pdre_gap_mem.sv =====
// ----------------------------------------------------------------------------
// pdre_gap_mem
// held gap byte store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdre_gap_mem #(
   parameter int DEPTH = pdre_pkg::GAP_LIMIT_DEF,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] gap_mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gap_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= gap_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pdre_span_chk.sv =====
// ----------------------------------------------------------------------------
// pdre_span_chk
// tells whether one of the enabled safe spans covers a gap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdre_span_chk #(
   parameter int NUM_SPANS   = pdre_pkg::NUM_SPANS_DEF,
   parameter int OFFSET_BITS = pdre_pkg::OFFSET_BITS_DEF
) (
   input  logic [1:0]                                  span_count,
   input  logic [NUM_SPANS-1:0][pdre_pkg::SPAN_BITS-1:0] span_lo,
   input  logic [NUM_SPANS-1:0][pdre_pkg::SPAN_BITS-1:0] span_hi,
   input  logic [OFFSET_BITS-1:0]                      gap_lo,
   input  logic [OFFSET_BITS-1:0]                      gap_hi,
   output logic                                        safe
);

   localparam int CW = (OFFSET_BITS > pdre_pkg::SPAN_BITS) ? OFFSET_BITS : pdre_pkg::SPAN_BITS;

   always_comb begin
      safe = 1'b0;
      for (int i = 0; i < NUM_SPANS; i++) begin
         if ((i < int'(span_count)) && (CW'(span_lo[i]) <= CW'(gap_lo))
             && (CW'(gap_hi) <= CW'(span_hi[i]))) begin
            safe = 1'b1;
         end
      end
   end

endmodule

// ===== hdl/page_delta_record_encoder.sv =====
// ----------------------------------------------------------------------------
// page_delta_record_encoder
// turns runs of differing bytes into address/length/data records per page
// ----------------------------------------------------------------------------
//  channel | ports                    | moves
//  req     | req_valid/ready/data     | one byte pair item
//  rsp     | rsp_valid/ready/data     | one output word with its offset
//  csr     | csr_write_en/index/wdata | register write, no wait
//
//  an item with no close and no merge ends with its entry step, items follow back to back while rsp is not stalled
//  a closing item passes its entry step, then a step for each close and done word;
//  a merged gap is read back through the single gap store read, one held byte per merge step
//  synchronous reset clears the stream state and registers
//  a stalled rsp holds the sequencer; a new item enters as the last step ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_delta_record_encoder #(
   parameter int PAGE_BYTES  = pdre_pkg::PAGE_BYTES_DEF,
   parameter int GAP_LIMIT   = pdre_pkg::GAP_LIMIT_DEF,
   parameter int NUM_SPANS   = pdre_pkg::NUM_SPANS_DEF,
   parameter int OFFSET_BITS = pdre_pkg::OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pdre_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pdre_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_en,
   input  logic [pdre_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pdre_pkg::WORD_BITS-1:0]        csr_wdata
);

   localparam int PAGE_LOG = $clog2(PAGE_BYTES);
   localparam int LEN_BITS = PAGE_LOG + 1;
   localparam int GAP_AW   = (GAP_LIMIT > 1) ? $clog2(GAP_LIMIT) : 1;
   localparam int GCW      = $clog2(GAP_LIMIT + 1);
   localparam int OB       = OFFSET_BITS;
   localparam int OWB      = pdre_pkg::OUT_OFF_BITS;
   localparam int WB       = pdre_pkg::WORD_BITS;
   localparam int FB       = pdre_pkg::FILL_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ENTRY   = 3'd1;
   localparam logic [2:0] ST_MERGE   = 3'd2;
   localparam logic [2:0] ST_CLOSE_D = 3'd3;
   localparam logic [2:0] ST_CLOSE_A = 3'd4;
   localparam logic [2:0] ST_CLOSE_L = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   localparam logic [FB-1:0] FILL_TOP = FB'(pdre_pkg::WORD_BYTES - 1);
   localparam logic [FB-1:0] FILL_SUB = FB'(pdre_pkg::WORD_BYTES - 2);

   // configuration
   logic [WB-1:0]                                  base_addr_ff, base_addr_in;
   logic [1:0]                                     span_cnt_ff, span_cnt_in;
   logic [NUM_SPANS-1:0][pdre_pkg::SPAN_BITS-1:0]  span_lo_ff, span_lo_in;
   logic [NUM_SPANS-1:0][pdre_pkg::SPAN_BITS-1:0]  span_hi_ff, span_hi_in;

   // sequencer and item
   logic [2:0]        state_ff, state_in;
   logic [7:0]        cur_ff, cur_in;
   logic              diff_ff, diff_in;
   logic              fin_ff, fin_in;
   logic              reopen_ff, reopen_in;
   logic [GAP_AW-1:0] gi_ff, gi_in;

   // stream state
   logic [OB-1:0]                    byte_off_ff, byte_off_in;
   logic                             run_open_ff, run_open_in;
   logic [OB-1:0]                    run_start_ff, run_start_in;
   logic [LEN_BITS-1:0]              run_len_ff, run_len_in;
   logic [OWB-1:0]                   rec_base_ff, rec_base_in;
   logic [OWB-1:0]                   wr_off_ff, wr_off_in;
   logic [WB-1:0]                    asm_ff, asm_in;
   logic [FB-1:0]                    fill_ff, fill_in;
   logic [GCW-1:0]                   gap_cnt_ff, gap_cnt_in;
   logic [pdre_pkg::REC_BITS-1:0]    rec_cnt_ff, rec_cnt_in;
   logic [pdre_pkg::PAY_BITS-1:0]    pay_cnt_ff, pay_cnt_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   pdre_pkg::rsp_type rsp_ff, rsp_nx;

   logic              go, emit, accept, page_end, close_req, safe, merge_final;
   logic [2:0]        step_nx;
   logic [GCW-1:0]    rem;
   logic [WB-1:0]     a1;
   logic              mem_we;
   logic [GAP_AW-1:0] mem_ra;
   logic [7:0]        mem_rd;
   logic [OB-1:0]     gap_lo;

   function automatic logic [WB-1:0] put_byte(input logic [WB-1:0] w, input logic [FB-1:0] pos,
                                              input logic [7:0] b);
      put_byte = w | (WB'(b) << {pos, 3'b000});
   endfunction

   function automatic logic [2:0] tail_state(input logic open_after, input logic fill_nz,
                                             input logic creq, input logic fin);
      if (open_after && creq) begin
         tail_state = fill_nz ? ST_CLOSE_D : ST_CLOSE_A;
      end else if (fin) begin
         tail_state = ST_DONE;
      end else begin
         tail_state = ST_IDLE;
      end
   endfunction

   assign gap_lo = byte_off_ff - OB'(gap_cnt_ff);

   pdre_span_chk #(
      .NUM_SPANS  (NUM_SPANS),
      .OFFSET_BITS(OB)
   ) u_span_chk (
      .span_count(span_cnt_ff),
      .span_lo   (span_lo_ff),
      .span_hi   (span_hi_ff),
      .gap_lo    (gap_lo),
      .gap_hi    (byte_off_ff),
      .safe      (safe)
   );

   pdre_gap_mem #(
      .DEPTH(GAP_LIMIT),
      .AW   (GAP_AW)
   ) u_gap_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(gap_cnt_ff[GAP_AW-1:0]),
      .wr_data(cur_ff),
      .rd_addr(mem_ra),
      .rd_data(mem_rd)
   );

   assign go          = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign page_end    = &byte_off_ff[PAGE_LOG-1:0];
   assign close_req   = fin_ff || page_end;
   assign merge_final = ((GCW'(gi_ff) + GCW'(1)) == gap_cnt_ff);
   assign rem         = gap_cnt_ff - GCW'(gi_ff);
   assign a1          = put_byte(asm_ff, fill_ff, mem_rd);
   assign mem_ra      = (state_ff == ST_MERGE && go) ? (gi_ff + GAP_AW'(1)) :
                        (state_ff == ST_MERGE) ? gi_ff : '0;

   always_comb begin
      base_addr_in = base_addr_ff;
      span_cnt_in  = span_cnt_ff;
      span_lo_in   = span_lo_ff;
      span_hi_in   = span_hi_ff;
      if (csr_write_en) begin
         if (csr_index == pdre_pkg::REG_BASE_ADDRESS) begin
            base_addr_in = csr_wdata;
         end
         if (csr_index == pdre_pkg::REG_SPAN_COUNT) begin
            span_cnt_in = csr_wdata[1:0];
         end
         for (int k = 0; k < NUM_SPANS; k++) begin
            if (csr_index == (pdre_pkg::REG_SPAN0_START + 3'(2 * k))) begin
               span_lo_in[k] = csr_wdata[pdre_pkg::SPAN_BITS-1:0];
            end
            if (csr_index == (pdre_pkg::REG_SPAN0_START + 3'(2 * k + 1))) begin
               span_hi_in[k] = csr_wdata[pdre_pkg::SPAN_BITS-1:0];
            end
         end
      end
   end

   always_comb begin
      step_nx      = state_ff;
      reopen_in    = reopen_ff;
      gi_in        = gi_ff;
      byte_off_in  = byte_off_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      rec_base_in  = rec_base_ff;
      wr_off_in    = wr_off_ff;
      asm_in       = asm_ff;
      fill_in      = fill_ff;
      gap_cnt_in   = gap_cnt_ff;
      rec_cnt_in   = rec_cnt_ff;
      pay_cnt_in   = pay_cnt_ff;
      mem_we       = 1'b0;
      emit         = 1'b0;
      rsp_nx       = '0;

      if (go) begin
         unique case (state_ff)
            ST_ENTRY: begin
               if (diff_ff) begin
                  if (run_open_ff && gap_cnt_ff != '0) begin
                     if (safe) begin
                        gi_in   = '0;
                        step_nx = ST_MERGE;
                     end else begin
                        reopen_in = 1'b1;
                        step_nx   = (fill_ff != '0) ? ST_CLOSE_D : ST_CLOSE_A;
                     end
                  end else if (!run_open_ff) begin
                     run_open_in  = 1'b1;
                     run_start_in = byte_off_ff;
                     run_len_in   = LEN_BITS'(1);
                     gap_cnt_in   = '0;
                     asm_in       = WB'(cur_ff);
                     fill_in      = FB'(1);
                     rec_base_in  = wr_off_ff;
                     wr_off_in    = wr_off_ff + OWB'(pdre_pkg::HDR_BYTES);
                     step_nx      = tail_state(1'b1, 1'b1, close_req, fin_ff);
                  end else begin
                     run_len_in = run_len_ff + LEN_BITS'(1);
                     if (fill_ff == FILL_TOP) begin
                        emit              = 1'b1;
                        rsp_nx.out_offset = wr_off_ff;
                        rsp_nx.out_word   = put_byte(asm_ff, fill_ff, cur_ff);
                        rsp_nx.word_kind  = pdre_pkg::KIND_DATA;
                        wr_off_in         = wr_off_ff + OWB'(pdre_pkg::WORD_BYTES);
                        asm_in            = '0;
                        fill_in           = '0;
                     end else begin
                        asm_in  = put_byte(asm_ff, fill_ff, cur_ff);
                        fill_in = fill_ff + FB'(1);
                     end
                     step_nx = tail_state(1'b1, fill_in != '0, close_req, fin_ff);
                  end
               end else if (run_open_ff && int'(gap_cnt_ff) < GAP_LIMIT) begin
                  mem_we     = 1'b1;
                  gap_cnt_in = gap_cnt_ff + GCW'(1);
                  step_nx    = tail_state(1'b1, fill_ff != '0, close_req, fin_ff);
               end else if (run_open_ff) begin
                  reopen_in = 1'b0;
                  step_nx   = (fill_ff != '0) ? ST_CLOSE_D : ST_CLOSE_A;
               end else begin
                  step_nx = tail_state(1'b0, 1'b0, close_req, fin_ff);
               end
            end
            ST_MERGE: begin
               gi_in = gi_ff + GAP_AW'(1);
               if (!merge_final) begin
                  run_len_in = run_len_ff + LEN_BITS'(1);
                  if (fill_ff == FILL_TOP) begin
                     emit              = 1'b1;
                     rsp_nx.out_offset = wr_off_ff;
                     rsp_nx.out_word   = a1;
                     rsp_nx.word_kind  = pdre_pkg::KIND_DATA;
                     rsp_nx.last_of_run = (int'(rem) < pdre_pkg::WORD_BYTES) && !close_req;
                     wr_off_in         = wr_off_ff + OWB'(pdre_pkg::WORD_BYTES);
                     asm_in            = '0;
                     fill_in           = '0;
                  end else begin
                     asm_in  = a1;
                     fill_in = fill_ff + FB'(1);
                  end
                  step_nx = ST_MERGE;
               end else begin
                  run_len_in = run_len_ff + LEN_BITS'(2);
                  gap_cnt_in = '0;
                  if (fill_ff == FILL_TOP) begin
                     emit              = 1'b1;
                     rsp_nx.out_offset = wr_off_ff;
                     rsp_nx.out_word   = a1;
                     rsp_nx.word_kind  = pdre_pkg::KIND_DATA;
                     wr_off_in         = wr_off_ff + OWB'(pdre_pkg::WORD_BYTES);
                     asm_in            = WB'(cur_ff);
                     fill_in           = FB'(1);
                  end else if (fill_ff == FILL_SUB) begin
                     emit              = 1'b1;
                     rsp_nx.out_offset = wr_off_ff;
                     rsp_nx.out_word   = put_byte(a1, FILL_TOP, cur_ff);
                     rsp_nx.word_kind  = pdre_pkg::KIND_DATA;
                     wr_off_in         = wr_off_ff + OWB'(pdre_pkg::WORD_BYTES);
                     asm_in            = '0;
                     fill_in           = '0;
                  end else begin
                     asm_in  = put_byte(a1, fill_ff + FB'(1), cur_ff);
                     fill_in = fill_ff + FB'(2);
                  end
                  step_nx = tail_state(1'b1, fill_in != '0, close_req, fin_ff);
                  rsp_nx.last_of_run = (step_nx == ST_IDLE);
               end
            end
            ST_CLOSE_D: begin
               emit              = 1'b1;
               rsp_nx.out_offset = wr_off_ff;
               rsp_nx.out_word   = asm_ff;
               rsp_nx.word_kind  = pdre_pkg::KIND_DATA;
               wr_off_in         = wr_off_ff + OWB'(pdre_pkg::WORD_BYTES);
               step_nx           = ST_CLOSE_A;
            end
            ST_CLOSE_A: begin
               emit              = 1'b1;
               rsp_nx.out_offset = rec_base_ff;
               rsp_nx.out_word   = base_addr_ff + WB'(run_start_ff);
               rsp_nx.word_kind  = pdre_pkg::KIND_ADDR;
               step_nx           = ST_CLOSE_L;
            end
            ST_CLOSE_L: begin
               emit              = 1'b1;
               rsp_nx.out_offset = rec_base_ff + OWB'(pdre_pkg::WORD_BYTES);
               rsp_nx.out_word   = WB'(run_len_ff);
               rsp_nx.word_kind  = pdre_pkg::KIND_LEN;
               rec_cnt_in        = rec_cnt_ff + pdre_pkg::REC_BITS'(1);
               pay_cnt_in        = pay_cnt_ff + pdre_pkg::PAY_BITS'(run_len_ff);
               gap_cnt_in        = '0;
               reopen_in         = 1'b0;
               if (reopen_ff) begin
                  run_open_in  = 1'b1;
                  run_start_in = byte_off_ff;
                  run_len_in   = LEN_BITS'(1);
                  asm_in       = WB'(cur_ff);
                  fill_in      = FB'(1);
                  rec_base_in  = wr_off_ff;
                  wr_off_in    = wr_off_ff + OWB'(pdre_pkg::HDR_BYTES);
               end else begin
                  run_open_in = 1'b0;
                  run_len_in  = '0;
                  asm_in      = '0;
                  fill_in     = '0;
               end
               step_nx = tail_state(reopen_ff, 1'b1, close_req, fin_ff);
            end
            ST_DONE: begin
               emit                 = 1'b1;
               rsp_nx.out_offset    = wr_off_ff;
               rsp_nx.out_word      = WB'(wr_off_ff);
               rsp_nx.word_kind     = pdre_pkg::KIND_DONE;
               rsp_nx.record_total  = rec_cnt_ff;
               rsp_nx.payload_total = pay_cnt_ff;
               byte_off_in  = '0;
               run_open_in  = 1'b0;
               run_start_in = '0;
               run_len_in   = '0;
               rec_base_in  = '0;
               wr_off_in    = '0;
               asm_in       = '0;
               fill_in      = '0;
               gap_cnt_in   = '0;
               rec_cnt_in   = '0;
               pay_cnt_in   = '0;
               step_nx      = ST_IDLE;
            end
            default: begin
               step_nx = ST_IDLE;
            end
         endcase

         if (state_ff != ST_MERGE) begin
            rsp_nx.last_of_run = (step_nx == ST_IDLE);
         end
         if (step_nx == ST_IDLE && !fin_ff) begin
            byte_off_in = byte_off_ff + OB'(1);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE) || (go && step_nx == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = go ? step_nx : state_ff;
      cur_in   = cur_ff;
      diff_in  = diff_ff;
      fin_in   = fin_ff;
      if (accept) begin
         state_in = ST_ENTRY;
         cur_in   = req_data.cur_byte;
         diff_in  = (req_data.cur_byte != req_data.prev_byte);
         fin_in   = req_data.final_byte;
      end
      if (go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reopen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_addr_ff <= '0;
         span_cnt_ff  <= '0;
         span_lo_ff   <= '0;
         span_hi_ff   <= '0;
         byte_off_ff  <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         rec_base_ff  <= '0;
         wr_off_ff    <= '0;
         asm_ff       <= '0;
         fill_ff      <= '0;
         gap_cnt_ff   <= '0;
         rec_cnt_ff   <= '0;
         pay_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         reopen_ff    <= reopen_in;
         rsp_valid_ff <= rsp_valid_in;
         base_addr_ff <= base_addr_in;
         span_cnt_ff  <= span_cnt_in;
         span_lo_ff   <= span_lo_in;
         span_hi_ff   <= span_hi_in;
         byte_off_ff  <= byte_off_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         rec_base_ff  <= rec_base_in;
         wr_off_ff    <= wr_off_in;
         asm_ff       <= asm_in;
         fill_ff      <= fill_in;
         gap_cnt_ff   <= gap_cnt_in;
         rec_cnt_ff   <= rec_cnt_in;
         pay_cnt_ff   <= pay_cnt_in;
      end
   end

   // item context and result word
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      diff_ff   <= diff_in;
      fin_ff    <= fin_in;
      gi_ff     <= gi_in;
      if (go && emit) begin
         rsp_ff <= rsp_nx;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/pdre_checker.sv =====
// ----------------------------------------------------------------------------
// pdre_checker
// port level checks on the result channel of the record encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_delta_record_encoder_assert.svh"

module pdre_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input pdre_pkg::rsp_type rsp_data
);

   `PDRE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp item dropped")
   `PDRE_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp item changed")
   `PDRE_ASSERT(a_done_last, rsp_valid && rsp_data.word_kind == pdre_pkg::KIND_DONE |-> rsp_data.last_of_run, "done not last")
   `PDRE_ASSERT(a_totals_zero, rsp_valid && rsp_data.word_kind != pdre_pkg::KIND_DONE |-> rsp_data.record_total == '0 && rsp_data.payload_total == '0, "totals outside done")
   `PDRE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind page_delta_record_encoder pdre_checker u_pdre_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// page delta record encoder testbench
// drives byte pairs through several register settings, predicts every output
// word with a scoreboard model and checks each word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam logic [pdre_pkg::CSR_INDEX_BITS-1:0] REG_SPAN0_END   = 3'd3;
   localparam logic [pdre_pkg::CSR_INDEX_BITS-1:0] REG_SPAN1_START = 3'd4;
   localparam logic [pdre_pkg::CSR_INDEX_BITS-1:0] REG_SPAN1_END   = 3'd5;
   localparam logic [pdre_pkg::CSR_INDEX_BITS-1:0] REG_SPAN2_START = 3'd6;
   localparam logic [pdre_pkg::CSR_INDEX_BITS-1:0] REG_SPAN2_END   = 3'd7;
   localparam int PAGE = 4096;
   localparam int GAPS = 16;

   class delta_scoreboard;
      bit [63:0] base_addr;
      bit [1:0]  span_n;
      bit [31:0] span_lo [3];
      bit [31:0] span_hi [3];
      bit [31:0] offset;
      bit        open;
      bit [31:0] start;
      bit [12:0] run_len;
      bit [39:0] rec_base;
      bit [39:0] wr_off;
      bit [63:0] assembly;
      int        fill;
      bit [7:0]  gap [GAPS];
      int        gap_n;
      bit [31:0] records;
      bit [32:0] payload;
      pdre_pkg::rsp_type words [$];
      int        errors;
      int        checked;
      int        dones;

      function void set_reg(logic [pdre_pkg::CSR_INDEX_BITS-1:0] idx, bit [63:0] v);
         case (idx)
            pdre_pkg::REG_BASE_ADDRESS: base_addr = v;
            pdre_pkg::REG_SPAN_COUNT:   span_n = v[1:0];
            pdre_pkg::REG_SPAN0_START:  span_lo[0] = v[31:0];
            REG_SPAN0_END:              span_hi[0] = v[31:0];
            REG_SPAN1_START:            span_lo[1] = v[31:0];
            REG_SPAN1_END:              span_hi[1] = v[31:0];
            REG_SPAN2_START:            span_lo[2] = v[31:0];
            REG_SPAN2_END:              span_hi[2] = v[31:0];
            default: ;
         endcase
      endfunction

      function void emit(bit [39:0] off, bit [63:0] w, logic [1:0] kind, bit [31:0] rec,
                         bit [32:0] pay);
         pdre_pkg::rsp_type r;
         r.out_offset = off;
         r.out_word = w;
         r.word_kind = kind;
         r.record_total = rec;
         r.payload_total = pay;
         r.last_of_run = 1'b0;
         words.push_back(r);
      endfunction

      function void append(bit [7:0] b);
         assembly |= 64'(b) << (8 * fill);
         fill++;
         run_len++;
         if (fill == pdre_pkg::WORD_BYTES) begin
            emit(wr_off, assembly, pdre_pkg::KIND_DATA, 0, 0);
            wr_off += 40'(pdre_pkg::WORD_BYTES);
            assembly = 0;
            fill = 0;
         end
      endfunction

      function void open_run(bit [31:0] off);
         open = 1;
         start = off;
         run_len = 0;
         gap_n = 0;
         assembly = 0;
         fill = 0;
         rec_base = wr_off;
         wr_off += 40'(pdre_pkg::HDR_BYTES);
      endfunction

      function void close_run();
         if (fill > 0) begin
            emit(wr_off, assembly, pdre_pkg::KIND_DATA, 0, 0);
            wr_off += 40'(pdre_pkg::WORD_BYTES);
         end
         emit(rec_base, base_addr + 64'(start), pdre_pkg::KIND_ADDR, 0, 0);
         emit(rec_base + 40'(pdre_pkg::WORD_BYTES), 64'(run_len), pdre_pkg::KIND_LEN, 0, 0);
         records++;
         payload += 33'(run_len);
         open = 0;
         run_len = 0;
         gap_n = 0;
         assembly = 0;
         fill = 0;
      endfunction

      function bit gap_safe(bit [31:0] lo, bit [31:0] hi);
         for (int i = 0; i < span_n; i++)
            if (span_lo[i] <= lo && hi <= span_hi[i])
               return 1;
         return 0;
      endfunction

      function void note_item(pdre_pkg::req_type d);
         int first;
         bit [31:0] nxt;
         pdre_pkg::rsp_type r;
         first = words.size();
         nxt = offset + 1;
         if (d.cur_byte != d.prev_byte) begin
            if (open && gap_n > 0) begin
               if (gap_safe(offset - 32'(gap_n), offset)) begin
                  for (int i = 0; i < gap_n; i++)
                     append(gap[i]);
                  gap_n = 0;
               end else begin
                  close_run();
                  open_run(offset);
               end
            end else if (!open) begin
               open_run(offset);
            end
            append(d.cur_byte);
         end else if (open) begin
            if (gap_n < GAPS) begin
               gap[gap_n] = d.cur_byte;
               gap_n++;
            end else begin
               close_run();
            end
         end
         if (open && (d.final_byte || (nxt % PAGE) == 0))
            close_run();
         if (d.final_byte) begin
            emit(wr_off, 64'(wr_off), pdre_pkg::KIND_DONE, records, payload);
            offset = 0;
            open = 0;
            start = 0;
            run_len = 0;
            rec_base = 0;
            wr_off = 0;
            assembly = 0;
            fill = 0;
            gap_n = 0;
            records = 0;
            payload = 0;
         end else begin
            offset = nxt;
         end
         if (words.size() > first) begin
            r = words.pop_back();
            r.last_of_run = 1'b1;
            words.push_back(r);
         end
      endfunction

      function void check_word(pdre_pkg::rsp_type a);
         pdre_pkg::rsp_type e;
         checked++;
         if (words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: %p", a);
            return;
         end
         e = words.pop_front();
         if (e.word_kind == pdre_pkg::KIND_DONE)
            dones++;
         if (a.out_offset !== e.out_offset || a.out_word !== e.out_word ||
             a.word_kind !== e.word_kind || a.record_total !== e.record_total ||
             a.payload_total !== e.payload_total || a.last_of_run !== e.last_of_run) begin
            errors++;
            if (errors <= 10)
               $display("word %0d mismatch\n  expected %p\n  actual   %p", checked, e, a);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   pdre_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   pdre_pkg::rsp_type rsp_data;
   logic csr_write_en = 0;
   logic [pdre_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [pdre_pkg::WORD_BITS-1:0] csr_wdata = '0;

   delta_scoreboard sb = new();
   bit calm = 0;
   int hold_off = 0;
   int items = 0;
   int phases = 0;

   page_delta_record_encoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stalls, with one long hold-off counted here
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 14;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_data);

   task automatic write_reg(logic [pdre_pkg::CSR_INDEX_BITS-1:0] idx, logic [63:0] v);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic set_spans(logic [1:0] n, logic [31:0] l0, logic [31:0] h0,
                            logic [31:0] l1, logic [31:0] h1,
                            logic [31:0] l2, logic [31:0] h2);
      write_reg(pdre_pkg::REG_SPAN_COUNT, 64'(n));
      write_reg(pdre_pkg::REG_SPAN0_START, 64'(l0));
      write_reg(REG_SPAN0_END, 64'(h0));
      write_reg(REG_SPAN1_START, 64'(l1));
      write_reg(REG_SPAN1_END, 64'(h1));
      write_reg(REG_SPAN2_START, 64'(l2));
      write_reg(REG_SPAN2_END, 64'(h2));
   endtask

   // called just after a falling edge, returns just after one
   task automatic send(logic [7:0] c, logic [7:0] p, logic f);
      pdre_pkg::req_type d;
      d.cur_byte = c;
      d.prev_byte = p;
      d.final_byte = f;
      if (!calm && $urandom_range(99) < 14) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(d);
      items++;
      @(negedge clock);
   endtask

   task automatic send_diff(int n, logic f);
      logic [7:0] p;
      for (int i = 0; i < n; i++) begin
         p = 8'($urandom);
         send(p ^ 8'($urandom_range(1, 255)), p, f && i == n - 1);
      end
   endtask

   task automatic send_same(int n, logic f);
      logic [7:0] v;
      for (int i = 0; i < n; i++) begin
         v = 8'($urandom);
         send(v, v, f && i == n - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // mostly well-formed runs and gaps, some noise, final byte at the end
   task automatic random_buffer(int len);
      int n;
      int k;
      n = 0;
      while (n < len - 1) begin
         k = $urandom_range(1, 12);
         if ($urandom_range(99) < 15) begin
            for (int i = 0; i < k; i++) send(8'($urandom), 8'($urandom), 0);
         end else begin
            send_diff(k, 0);
            n += k;
            k = $urandom_range(99) < 80 ? $urandom_range(1, 16) : $urandom_range(17, 24);
            send_same(k, 0);
         end
         n += k;
      end
      if ($urandom_range(1)) send_diff(1, 1);
      else send_same(1, 1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // merging off, extreme bytes, gap then differing byte
      send(8'hFF, 8'h00, 0);
      send(8'h00, 8'hFF, 0);
      send(8'hFF, 8'hFF, 0);
      send(8'h00, 8'h00, 0);
      send(8'h5A, 8'hA5, 0);
      send(8'h00, 8'h00, 1);
      send(8'h12, 8'h34, 1);
      send_same(1, 1);
      drain();

      // all gaps safe, largest base: gap of limit merges, one more closes
      write_reg(pdre_pkg::REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
      set_spans(2'd1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
      send_diff(3, 0);
      send_same(16, 0);
      send_diff(9, 0);
      send_same(17, 0);
      send_diff(2, 0);
      send_same(4, 1);
      drain();

      // narrow spans: gap on a span edge merges, gap past the end reopens
      write_reg(pdre_pkg::REG_BASE_ADDRESS, 64'h0);
      set_spans(2'd3, 32'd10, 32'd20, 32'd30, 32'd40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      calm = 1;
      send_same(8, 0);
      send_diff(2, 0);
      send_same(5, 0);
      send_diff(1, 0);
      send_same(5, 0);
      send_diff(1, 0);
      send_diff(8, 0);
      send_same(4, 0);
      send_diff(1, 0);
      send_same(2, 0);
      send_diff(6, 1);
      calm = 0;
      drain();
      phases = 3;

      for (int ph = 0; ph < 5; ph++) begin
         write_reg(pdre_pkg::REG_BASE_ADDRESS, {$urandom, $urandom});
         case (ph)
            0: set_spans(2'd0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
            1: set_spans(2'd1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
            default: set_spans(2'($urandom_range(1, 3)),
                               $urandom_range(0, 40), $urandom_range(20, 90),
                               $urandom_range(0, 40), $urandom_range(20, 90),
                               $urandom_range(0, 40), $urandom_range(20, 90));
         endcase
         calm = (ph == 1);
         for (int b = 0; b < 2; b++) begin
            if (ph == 3 && b == 0) hold_off = 300;
            random_buffer($urandom_range(6, 20));
         end
         calm = 0;
         drain();
         phases++;
      end

      $display("covered %0d items in %0d register settings, %0d words, %0d buffers",
               items, phases, sb.checked, sb.dones);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
